>>> sv/tebt_pkg.sv
// Shared types and constants of the trace event boundary tracker.
`default_nettype none

package tebt_pkg;

  // Fixed field widths of the item, result and configuration words.
  localparam int unsigned OpW      = 3;
  localparam int unsigned EntryW   = 6;
  localparam int unsigned IdW      = 32;
  localparam int unsigned TsW      = 64;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned CountW   = 32;
  localparam int unsigned TotalW   = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // Operation codes carried by an item word.
  typedef enum logic [OpW-1:0] {
    OP_LOAD    = 3'd0,
    OP_SAMPLE  = 3'd1,
    OP_EVENT   = 3'd2,
    OP_STOP    = 3'd3,
    OP_RESTART = 3'd4
  } tebt_op_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_NUM_EVENTS  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_SAMPLES = 1'd1;

  // Register reset values.
  localparam logic [TotalW-1:0] NUM_EVENTS_RST  = 7'd0;
  localparam logic [CountW-1:0] MAX_SAMPLES_RST = 32'd65536;

endpackage

`default_nettype wire

>>> sv/tebt_if.sv
// Handshake channels of the trace event boundary tracker: items, results, configuration.
`default_nettype none

interface tebt_item_if;
  import tebt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [EntryW-1:0] entry_index;
  logic [IdW-1:0]    trace_id;
  logic [TsW-1:0]    timestamp;

  modport source (output valid, opcode, entry_index, trace_id, timestamp, input ready);
  modport sink   (input valid, opcode, entry_index, trace_id, timestamp, output ready);
endinterface

interface tebt_result_if;
  import tebt_pkg::*;

  logic              valid;
  logic              ready;
  logic              boundary_valid;
  logic [SlotW-1:0]  boundary_slot;
  logic [IdW-1:0]    boundary_event_id;
  logic [CountW-1:0] boundary_sample_count;
  logic [TsW-1:0]    boundary_time;
  logic [TotalW-1:0] boundary_total;
  logic              sample_accepted;
  logic              truncated_flag;
  logic              capture_done;

  modport source (
    output valid, boundary_valid, boundary_slot, boundary_event_id, boundary_sample_count,
           boundary_time, boundary_total, sample_accepted, truncated_flag, capture_done,
    input  ready
  );
  modport sink (
    input  valid, boundary_valid, boundary_slot, boundary_event_id, boundary_sample_count,
           boundary_time, boundary_total, sample_accepted, truncated_flag, capture_done,
    output ready
  );
endinterface

interface tebt_cfg_if;
  import tebt_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/trace_event_boundary_tracker_core.sv
// Top level of the trace event boundary tracker: configuration registers, table and sequencer.
//
// Each item word produces exactly one result word. Load, sample, stop and restart words, unused
// opcodes and event words that find capture already done pass through the execute state alone;
// an event word that scans walks the identifier table through the single read port of its
// memory, one slot per cycle, stopping at the first unseen match or at the last slot below the
// smaller of the configured event count and MAX_EVENTS.
// A finished result waits in an output register, so the next word is accepted while the result
// is still pending; a further result only waits if that register is still full. Configuration
// writes are always ready and must only be issued while idle.
`default_nettype none

module trace_event_boundary_tracker_core #(
  parameter int unsigned MAX_EVENTS = 64,
  parameter int unsigned ID_WIDTH   = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tebt_item_if.sink     item_i,
  tebt_result_if.source result_o,
  tebt_cfg_if.sink      cfg_i
);
  import tebt_pkg::*;

  localparam int unsigned IdxW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  logic [TotalW-1:0]   num_events_q;
  logic [CountW-1:0]   max_samples_q;

  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic                mem_re;
  logic [IdxW-1:0]     mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_events_q  <= NUM_EVENTS_RST;
      max_samples_q <= MAX_SAMPLES_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_NUM_EVENTS:  num_events_q  <= cfg_i.data[TotalW-1:0];
        REG_MAX_SAMPLES: max_samples_q <= cfg_i.data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Expected event identifier table.
  tebt_table_mem #(
    .DEPTH (MAX_EVENTS),
    .WIDTH (ID_WIDTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer with run state and result register.
  tebt_ctrl #(
    .MAX_EVENTS (MAX_EVENTS),
    .ID_WIDTH   (ID_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .result_o      (result_o),
    .num_events_i  (num_events_q),
    .max_samples_i (max_samples_q),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

endmodule

`default_nettype wire

>>> sv/tebt_table_mem.sv
// Event identifier table: one write port, one read port, registered read data.
`default_nettype none

module tebt_table_mem #(
  parameter  int unsigned DEPTH = 64,
  parameter  int unsigned WIDTH = 32,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/tebt_ctrl.sv
// Sequencer of the tracker: run state, table scan and the result word register.
`default_nettype none

module tebt_ctrl #(
  parameter  int unsigned MAX_EVENTS = 64,
  parameter  int unsigned ID_WIDTH   = 32,
  localparam int unsigned IdxW       = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tebt_item_if.sink                        item_i,
  tebt_result_if.source                    result_o,
  input  wire logic [tebt_pkg::TotalW-1:0] num_events_i,
  input  wire logic [tebt_pkg::CountW-1:0] max_samples_i,
  output logic                             mem_we_o,
  output logic      [IdxW-1:0]             mem_waddr_o,
  output logic      [ID_WIDTH-1:0]         mem_wdata_o,
  output logic                             mem_re_o,
  output logic      [IdxW-1:0]             mem_raddr_o,
  input  wire logic [ID_WIDTH-1:0]         mem_rdata_i
);
  import tebt_pkg::*;

  localparam int unsigned LimW     = $clog2(MAX_EVENTS + 1);
  localparam int unsigned EntryExW = EntryW + 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StScan = 2'd2;

  logic [1:0]            state_q;
  logic [OpW-1:0]        op_q;
  logic [ID_WIDTH-1:0]   id_q;
  logic [TsW-1:0]        ts_q;
  logic [IdxW-1:0]       ptr_q;

  logic [MAX_EVENTS-1:0] seen_q, seen_d;
  logic [CountW-1:0]     cnt_q, cnt_d;
  logic [TotalW-1:0]     bcnt_q, bcnt_d;
  logic                  trunc_q, trunc_d;
  logic                  stop_q, stop_d;

  logic                  out_valid_q;
  logic                  res_bvalid_d, res_accepted_d;
  logic [SlotW-1:0]      res_slot_d;
  logic [IdW-1:0]        res_id_d;
  logic [CountW-1:0]     res_count_d;
  logic [TsW-1:0]        res_time_d;

  logic                  accept;
  logic                  done_c;
  logic [LimW-1:0]       limit_c;
  logic                  start_scan;
  logic                  hit;
  logic                  last;
  logic                  fin;
  logic                  out_free;
  logic                  commit;

  // A new word is taken only between items; the scan never overlaps a table write.
  assign item_i.ready = (state_q == StIdle);
  assign accept       = item_i.valid && item_i.ready;

  assign done_c  = stop_q || (bcnt_q >= num_events_i);
  assign limit_c = (num_events_i >= TotalW'(MAX_EVENTS)) ? LimW'(MAX_EVENTS)
                                                         : num_events_i[LimW-1:0];

  assign start_scan = accept && (item_i.opcode == OP_EVENT) && !done_c && (limit_c != '0);

  // Table write happens right at the accept edge of a load.
  assign mem_we_o    = accept && (item_i.opcode == OP_LOAD) &&
                       ({1'b0, item_i.entry_index} < EntryExW'(MAX_EVENTS));
  assign mem_waddr_o = item_i.entry_index[IdxW-1:0];
  assign mem_wdata_o = item_i.trace_id[ID_WIDTH-1:0];

  // Scan: the read data in StScan belongs to slot ptr_q.
  assign hit  = (mem_rdata_i == id_q) && !seen_q[ptr_q];
  assign last = (LimW'(ptr_q) == (limit_c - LimW'(1)));
  assign fin  = (state_q == StExec) || ((state_q == StScan) && (hit || last));

  assign mem_re_o    = start_scan || ((state_q == StScan) && !fin);
  assign mem_raddr_o = start_scan ? '0 : ptr_q + IdxW'(1);

  assign out_free = !out_valid_q || result_o.ready;
  assign commit   = fin && out_free;

  // Run state and result word that the current item leaves behind.
  always_comb begin
    seen_d         = seen_q;
    cnt_d          = cnt_q;
    bcnt_d         = bcnt_q;
    trunc_d        = trunc_q;
    stop_d         = stop_q;
    res_bvalid_d   = 1'b0;
    res_accepted_d = 1'b0;
    res_slot_d     = '0;
    res_id_d       = '0;
    res_count_d    = '0;
    res_time_d     = '0;
    if (state_q == StScan) begin
      if (hit) begin
        seen_d[ptr_q] = 1'b1;
        bcnt_d        = bcnt_q + TotalW'(1);
        res_bvalid_d  = 1'b1;
        res_slot_d    = SlotW'(ptr_q);
        res_id_d      = IdW'(id_q);
        res_count_d   = cnt_q;
        res_time_d    = ts_q;
      end
    end else begin
      case (op_q)
        OP_SAMPLE: begin
          if (!done_c) begin
            if (cnt_q < max_samples_i) begin
              cnt_d          = cnt_q + CountW'(1);
              res_accepted_d = 1'b1;
            end else begin
              trunc_d = 1'b1;
            end
          end
        end
        OP_STOP: begin
          stop_d = 1'b1;
        end
        OP_RESTART: begin
          seen_d  = '0;
          cnt_d   = '0;
          bcnt_d  = '0;
          trunc_d = 1'b0;
          stop_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer and run state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      bcnt_q      <= '0;
      trunc_q     <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            ptr_q   <= '0;
            state_q <= start_scan ? StScan : StExec;
          end
        end
        StExec, StScan: begin
          if (commit) begin
            seen_q  <= seen_d;
            cnt_q   <= cnt_d;
            bcnt_q  <= bcnt_d;
            trunc_q <= trunc_d;
            stop_q  <= stop_d;
            state_q <= StIdle;
          end else if (!fin) begin
            ptr_q <= ptr_q + IdxW'(1);
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Item fields held for the duration of the item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= item_i.opcode;
      id_q <= item_i.trace_id[ID_WIDTH-1:0];
      ts_q <= item_i.timestamp;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      result_o.boundary_valid        <= res_bvalid_d;
      result_o.boundary_slot         <= res_slot_d;
      result_o.boundary_event_id     <= res_id_d;
      result_o.boundary_sample_count <= res_count_d;
      result_o.boundary_time         <= res_time_d;
      result_o.boundary_total        <= bcnt_d;
      result_o.sample_accepted       <= res_accepted_d;
      result_o.truncated_flag        <= trunc_d;
      result_o.capture_done          <= stop_d || (bcnt_d >= num_events_i);
    end
  end

  assign result_o.valid = out_valid_q;

endmodule

`default_nettype wire
